@@ hdl/sbd_pkg.sv @@
// Shared types and constants for the single-button dimmer.
package sbd_pkg;

    // Field widths.
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned WAIT_W  = 7;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] CFG_MAX_LEVEL  = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_MIN_LEVEL  = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_STEP_LEVEL = 2'd2;
    localparam logic [INDEX_W-1:0] CFG_HOLD_WAIT  = 2'd3;

    // Reset values.
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL   = 7'd100;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL   = 7'd4;
    localparam logic [LEVEL_W-1:0] RST_STEP_LEVEL  = 7'd4;
    localparam logic [WAIT_W-1:0]  RST_HOLD_WAIT   = 7'd10;
    localparam logic [LEVEL_W-1:0] RST_SAVED_LEVEL = 7'd20;

    // Lamp modes.
    typedef enum logic [2:0] {
        MODE_OFF         = 3'd0,
        MODE_ON          = 3'd1,
        MODE_UP          = 3'd2,
        MODE_HIGH        = 3'd3,
        MODE_HIGH_PRESSED = 3'd4,
        MODE_DOWN        = 3'd5,
        MODE_LOW         = 3'd6,
        MODE_LOW_PRESSED = 3'd7
    } t_mode;

    // Button events.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_HOLD    = 2'd3
    } t_event;

endpackage

@@ hdl/sbd_if.sv @@
// Handshake interfaces for the dimmer's input, result and configuration channels.

// Input channel: one button sample per word.
interface sbd_in_if;
    logic valid;
    logic ready;
    logic button_down;

    modport source (output valid, output button_down, input ready);
    modport sink   (input valid, input button_down, output ready);
endinterface

// Result channel: lamp state and the event of one tick per word.
interface sbd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] lamp_level;
    logic [2:0] lamp_mode;
    logic [1:0] button_event;

    modport source (output valid, output lamp_level, output lamp_mode,
                    output button_event, input ready);
    modport sink   (input valid, input lamp_level, input lamp_mode,
                    input button_event, output ready);
endinterface

// Configuration write channel: register index and data.
interface sbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/single_button_dimmer_unit.sv @@
// Single-button lamp dimmer: button samples in, lamp level, mode and event out.
//
// Usage: i_in carries one button sample per word, one word per button tick.
// Every accepted sample yields exactly one word on o_out with the lamp level,
// the lamp mode and the button event after that tick. i_cfg writes the four
// registers (max level, min level, step, hold wait); it is always ready. It
// must be written only while no sample is in flight; the block does not enforce it.
// Latency: the result of a sample is on o_out in the cycle after acceptance.
// Throughput: one sample per cycle while o_out takes its words. The event
// decode, mode update and the saturating add or subtract on the level all
// settle combinationally between the state registers and the result register.
// Stall: the result register holds its word while o_out.ready is low; a new
// sample is still taken in the cycle the held word leaves, so i_in.ready
// drops only while a result waits and the receiver does not take it.
// Reset: synchronous, active low. The lamp is off at level 0 with a saved
// level of 20, no button is held, the wait count is zero, the registers
// take their reset values and o_out is empty.
module single_button_dimmer_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sbd_in_if.sink    i_in,
    sbd_out_if.source o_out,
    sbd_cfg_if.sink   i_cfg
);
    import sbd_pkg::*;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_max_level;
    logic [LEVEL_W-1:0] r_min_level;
    logic [LEVEL_W-1:0] r_step_level;
    logic [WAIT_W-1:0]  r_hold_wait;

    // Tick state.
    logic               r_held;
    logic [WAIT_W-1:0]  r_wait;
    t_mode              r_mode;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_saved;

    // Next values.
    logic               n_held;
    logic [WAIT_W-1:0]  n_wait;
    t_event             n_event;
    t_mode              n_mode;
    logic [LEVEL_W-1:0] n_level;
    logic [LEVEL_W-1:0] n_saved;

    // Result register.
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    t_mode              r_out_mode;
    t_event             r_out_event;

    // Dimming arithmetic.
    logic [LEVEL_W:0]   up_sum;
    logic [LEVEL_W:0]   down_limit;
    logic [LEVEL_W-1:0] up_level;
    logic [LEVEL_W-1:0] down_level;

    logic in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level  <= RST_MAX_LEVEL;
            r_min_level  <= RST_MIN_LEVEL;
            r_step_level <= RST_STEP_LEVEL;
            r_hold_wait  <= RST_HOLD_WAIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_LEVEL:  r_max_level  <= i_cfg.data;
                CFG_MIN_LEVEL:  r_min_level  <= i_cfg.data;
                CFG_STEP_LEVEL: r_step_level <= i_cfg.data;
                CFG_HOLD_WAIT:  r_hold_wait  <= i_cfg.data;
            endcase
        end
    end

    // Event decode from the held flag and the wait count.
    always_comb begin
        n_held  = r_held;
        n_wait  = r_wait;
        n_event = EV_NONE;
        if (!i_in.button_down) begin
            if (r_held) begin
                // The wait count survives a release.
                n_held  = 1'b0;
                n_event = EV_RELEASE;
            end else begin
                n_wait = '0;
            end
        end else if (!r_held) begin
            n_held  = 1'b1;
            n_event = EV_PRESS;
        end else if (r_wait < r_hold_wait) begin
            n_wait = r_wait + 1'b1;
        end else begin
            n_event = EV_HOLD;
        end
    end

    // Saturating level steps in both directions.
    always_comb begin
        up_sum     = {1'b0, r_level} + {1'b0, r_step_level};
        down_limit = {1'b0, r_min_level} + {1'b0, r_step_level};
        up_level   = (up_sum > {1'b0, r_max_level}) ? r_max_level : up_sum[LEVEL_W-1:0];
        down_level = ({1'b0, r_level} > down_limit) ? r_level - r_step_level : r_min_level;
    end

    // Mode machine: next mode and levels for the decoded event.
    always_comb begin
        n_mode  = r_mode;
        n_level = r_level;
        n_saved = r_saved;
        unique case (r_mode)
            MODE_OFF: begin
                if (n_event == EV_PRESS) begin
                    n_level = r_saved;
                    n_mode  = MODE_ON;
                end
            end
            MODE_ON, MODE_UP: begin
                if (n_event == EV_RELEASE) begin
                    n_mode = MODE_HIGH;
                end else if (n_event == EV_HOLD) begin
                    n_level = up_level;
                    n_mode  = MODE_UP;
                end
            end
            MODE_HIGH: begin
                if (n_event == EV_PRESS) begin
                    n_mode = MODE_HIGH_PRESSED;
                end
            end
            MODE_HIGH_PRESSED: begin
                if (n_event == EV_RELEASE) begin
                    n_saved = r_level;
                    n_level = '0;
                    n_mode  = MODE_OFF;
                end else if (n_event == EV_HOLD) begin
                    n_level = down_level;
                    n_mode  = MODE_DOWN;
                end
            end
            MODE_DOWN: begin
                if (n_event == EV_RELEASE) begin
                    n_mode = MODE_LOW;
                end else if (n_event == EV_HOLD) begin
                    n_level = down_level;
                    n_mode  = MODE_DOWN;
                end
            end
            MODE_LOW: begin
                if (n_event == EV_PRESS) begin
                    n_mode = MODE_LOW_PRESSED;
                end
            end
            MODE_LOW_PRESSED: begin
                if (n_event == EV_RELEASE) begin
                    n_saved = r_level;
                    n_level = '0;
                    n_mode  = MODE_OFF;
                end else if (n_event == EV_HOLD) begin
                    n_level = up_level;
                    n_mode  = MODE_UP;
                end
            end
        endcase
    end

    // State registers advance once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_wait  <= '0;
            r_mode  <= MODE_OFF;
            r_level <= '0;
            r_saved <= RST_SAVED_LEVEL;
        end else if (in_accept) begin
            r_held  <= n_held;
            r_wait  <= n_wait;
            r_mode  <= n_mode;
            r_level <= n_level;
            r_saved <= n_saved;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_level <= n_level;
            r_out_mode  <= n_mode;
            r_out_event <= n_event;
        end
    end

    // Result outputs.
    always_comb begin
        o_out.valid        = r_out_valid;
        o_out.lamp_level   = r_out_level;
        o_out.lamp_mode    = r_out_mode;
        o_out.button_event = r_out_event;
    end

    // The lamp is dark whenever it is off.
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_OFF |-> r_level == '0)
        else $error("lamp off with nonzero level");

    // A pending result always shows the current lamp state.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.lamp_mode == r_mode && o_out.lamp_level == r_level))
        else $error("result word differs from lamp state");

    // A released button reports a release and clears the held flag.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in.button_down && r_held)
        |=> (!r_held && o_out.button_event == EV_RELEASE))
        else $error("release not reported");

    // A fresh press reports a press and sets the held flag.
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.button_down && !r_held)
        |=> (r_held && o_out.button_event == EV_PRESS))
        else $error("press not reported");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the single-button dimmer unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbd_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int LIMIT_CYCLES   = 400_000;
    localparam int HOLD_OFF_TICKS = 300;
    localparam int PHASE_SAMPLES  = 92;
    localparam int RANDOM_PHASES  = 8;

    // Expected contents of one result word.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_mode              mode;
        t_event             ev;
    } t_lamp_word;

    // Tracks the lamp state of the dimmer and checks each result word against it.
    class dimmer_tracker;
        logic [LEVEL_W-1:0] max_lvl;
        logic [LEVEL_W-1:0] min_lvl;
        logic [LEVEL_W-1:0] step_lvl;
        logic [WAIT_W-1:0]  hold_wait;
        bit                 held;
        logic [WAIT_W-1:0]  wait_cnt;
        t_mode              mode;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] saved;
        t_lamp_word         lamp_words_due[$];
        int                 errors;
        int                 words_checked;
        int                 events_seen[4];
        bit                 modes_seen[8];

        function new();
            max_lvl   = RST_MAX_LEVEL;
            min_lvl   = RST_MIN_LEVEL;
            step_lvl  = RST_STEP_LEVEL;
            hold_wait = RST_HOLD_WAIT;
            held      = 1'b0;
            wait_cnt  = '0;
            mode      = MODE_OFF;
            level     = '0;
            saved     = RST_SAVED_LEVEL;
            errors    = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MAX_LEVEL:  max_lvl   = val;
                CFG_MIN_LEVEL:  min_lvl   = val;
                CFG_STEP_LEVEL: step_lvl  = val;
                CFG_HOLD_WAIT:  hold_wait = val;
                default: ;
            endcase
        endfunction

        // Dimming up saturates at the upper level, compared as signed integers.
        function void raise_level();
            if (int'(level) > int'(max_lvl) - int'(step_lvl)) begin
                level = max_lvl;
            end else begin
                level = LEVEL_W'(int'(level) + int'(step_lvl));
            end
            mode = MODE_UP;
        endfunction

        function void lower_level();
            if (int'(level) > int'(min_lvl) + int'(step_lvl)) begin
                level = LEVEL_W'(int'(level) - int'(step_lvl));
            end else begin
                level = min_lvl;
            end
            mode = MODE_DOWN;
        endfunction

        function void save_and_off();
            saved = level;
            level = '0;
            mode  = MODE_OFF;
        endfunction

        // Advance the state by one accepted button sample and queue the word it yields.
        function void note_sample(bit down);
            t_event     ev;
            t_lamp_word w;
            if (!down) begin
                if (held) begin
                    held = 1'b0;
                    ev   = EV_RELEASE;
                end else begin
                    wait_cnt = '0;
                    ev       = EV_NONE;
                end
            end else if (!held) begin
                held = 1'b1;
                ev   = EV_PRESS;
            end else if (wait_cnt < hold_wait) begin
                wait_cnt = wait_cnt + 7'd1;
                ev       = EV_NONE;
            end else begin
                ev = EV_HOLD;
            end

            // Events without an entry for the current mode leave everything as is.
            case (mode)
                MODE_OFF: begin
                    if (ev == EV_PRESS) begin
                        level = saved;
                        mode  = MODE_ON;
                    end
                end
                MODE_ON, MODE_UP: begin
                    if (ev == EV_RELEASE) mode = MODE_HIGH;
                    else if (ev == EV_HOLD) raise_level();
                end
                MODE_HIGH: begin
                    if (ev == EV_PRESS) mode = MODE_HIGH_PRESSED;
                end
                MODE_HIGH_PRESSED: begin
                    if (ev == EV_RELEASE) save_and_off();
                    else if (ev == EV_HOLD) lower_level();
                end
                MODE_DOWN: begin
                    if (ev == EV_RELEASE) mode = MODE_LOW;
                    else if (ev == EV_HOLD) lower_level();
                end
                MODE_LOW: begin
                    if (ev == EV_PRESS) mode = MODE_LOW_PRESSED;
                end
                default: begin
                    if (ev == EV_RELEASE) save_and_off();
                    else if (ev == EV_HOLD) raise_level();
                end
            endcase

            w.level = level;
            w.mode  = mode;
            w.ev    = ev;
            lamp_words_due.push_back(w);
            events_seen[ev]++;
            modes_seen[mode] = 1'b1;
        endfunction

        // Compare one result word, field by field, with the oldest expectation.
        function void check_word(logic [6:0] lvl, logic [2:0] md, logic [1:0] ev);
            t_lamp_word w;
            if (lamp_words_due.size() == 0) begin
                $error("Result word with no sample pending: level %0d mode %0d event %0d",
                       lvl, md, ev);
                errors++;
                return;
            end
            w = lamp_words_due.pop_front();
            words_checked++;
            if (lvl !== w.level) begin
                $error("lamp_level mismatch: expected %0d, actual %0d", w.level, lvl);
                errors++;
            end
            if (md !== w.mode) begin
                $error("lamp_mode mismatch: expected %0d, actual %0d", w.mode, md);
                errors++;
            end
            if (ev !== w.ev) begin
                $error("button_event mismatch: expected %0d, actual %0d", w.ev, ev);
                errors++;
            end
        endfunction

        function int pending();
            return lamp_words_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbd_in_if  in_if();
    sbd_out_if out_if();
    sbd_cfg_if cfg_if();

    single_button_dimmer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    dimmer_tracker tracker = new();

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_req;
    bit sample_q[$];
    int samples_sent;
    int settings_used;

    // Free-running clock.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long.
    function automatic int idle_ticks(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Register value: now and then an extreme of the 7-bit field.
    function automatic logic [CFG_W-1:0] pick_cfg(int lo, int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 7'd127;
        return CFG_W'($urandom_range(lo, hi));
    endfunction

    // Offer one button sample and wait until the block takes the word.
    task automatic send_sample(input bit down);
        int gap;
        in_if.valid       <= 1'b1;
        in_if.button_down <= down;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.note_sample(down);
        samples_sent++;
        gap = idle_ticks(tx_idle_on);
        if (gap > 0) begin
            in_if.valid       <= 1'b0;
            in_if.button_down <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic write_settings(input logic [CFG_W-1:0] max_v, input logic [CFG_W-1:0] min_v,
                                  input logic [CFG_W-1:0] step_v, input logic [CFG_W-1:0] wait_v);
        logic [INDEX_W-1:0] idx_list[4];
        logic [CFG_W-1:0]   val_list[4];
        idx_list = '{CFG_MAX_LEVEL, CFG_MIN_LEVEL, CFG_STEP_LEVEL, CFG_HOLD_WAIT};
        val_list = '{max_v, min_v, step_v, wait_v};
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx_list[i];
            cfg_if.data  <= val_list[i];
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            tracker.write_reg(idx_list[i], val_list[i]);
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // Send every queued sample, then drop valid.
    task automatic play_samples();
        while (sample_q.size() != 0) send_sample(sample_q.pop_front());
        in_if.valid <= 1'b0;
    endtask

    // Wait until every expected word has come out.
    task automatic wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Build a run of button activity: mostly release-then-hold bursts, some noise.
    // Each burst ends with the button down, so a phase may end with it held.
    task automatic build_bursts(input int n_samples, input int wait_cfg);
        int up_len;
        int dn_len;
        while (sample_q.size() < n_samples) begin
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(1, 6)) sample_q.push_back(1'($urandom_range(0, 1)));
            end else begin
                // A single up tick lets the next press carry the wait count over.
                up_len = ($urandom_range(0, 9) < 4) ? 1 : $urandom_range(2, 4);
                dn_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                                     : wait_cfg + $urandom_range(1, 6);
                repeat (up_len) sample_q.push_back(1'b0);
                repeat (dn_len) sample_q.push_back(1'b1);
            end
        end
    endtask

    // Result side: checks every accepted word and stalls at random.
    initial begin : result_sink
        int stall_left;
        int gap;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                tracker.check_word(out_if.lamp_level, out_if.lamp_mode, out_if.button_event);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_TICKS;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                gap = idle_ticks(rx_idle_on);
                if (gap > 0) begin
                    stall_left   = gap - 1;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        bit directed_seq[] = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 0, 0, 1, 0,
                               1, 1, 1, 0, 0, 1, 1, 1, 1, 0, 1, 0};
        int modes_hit;
        logic [CFG_W-1:0] max_v, min_v, step_v, wait_v;

        in_if.valid       = 1'b0;
        in_if.button_down = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_MAX_LEVEL;
        cfg_if.data       = '0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        hold_off_req      = 1'b0;
        samples_sent      = 0;
        settings_used     = 0;
        i_rst_n           = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through all eight modes with a step wider than the range,
        // a one-tick hold wait, and a press right after a release.
        write_settings(RST_MAX_LEVEL, RST_MIN_LEVEL, 7'd127, 7'd1);
        foreach (directed_seq[i]) sample_q.push_back(directed_seq[i]);
        play_samples();
        wait_drained();

        // Random phases, each with its own register settings.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin max_v = 7'd100; min_v = 7'd0;   step_v = 7'd1;   wait_v = 7'd0;   end
                1: begin max_v = 7'd0;   min_v = 7'd127; step_v = 7'd127; wait_v = 7'd3;   end
                2: begin max_v = 7'd127; min_v = 7'd0;   step_v = 7'd1;   wait_v = 7'd127; end
                default: begin
                    max_v  = pick_cfg(0, 100);
                    min_v  = pick_cfg(0, 100);
                    step_v = pick_cfg(1, 100);
                    wait_v = pick_cfg(0, 8);
                end
            endcase
            write_settings(max_v, min_v, step_v, wait_v);
            tx_idle_on = !(p == 1 || p == 3);
            rx_idle_on = !(p == 2 || p == 5);
            // Long receiver hold-off while the sender keeps offering samples.
            if (p == 3) hold_off_req = 1'b1;
            build_bursts(PHASE_SAMPLES, int'(wait_v));
            play_samples();
            wait_drained();
        end

        if (tracker.pending() != 0) begin
            $error("%0d expected words never arrived", tracker.pending());
            tracker.errors++;
        end
        modes_hit = 0;
        foreach (tracker.modes_seen[m]) modes_hit += tracker.modes_seen[m];
        $display("Covered %0d button samples under %0d register settings, %0d words checked.",
                 samples_sent, settings_used, tracker.words_checked);
        $display("Events none/press/release/hold: %0d/%0d/%0d/%0d; lamp modes reached: %0d of 8.",
                 tracker.events_seen[0], tracker.events_seen[1], tracker.events_seen[2],
                 tracker.events_seen[3], modes_hit);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/sbd_pkg.sv
hdl/sbd_if.sv
hdl/single_button_dimmer_unit.sv
dv/tb_top.sv
